// ===== design/mms_pkg.sv =====
package mms_pkg;

  // Word width and default stack depth
  localparam int DATA_WIDTH = 16;
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Input word
  typedef struct packed {
    logic  opcode;
    data_t value;
  } req_t;

  // Result word
  typedef struct packed {
    data_t   popped;
    data_t   cur_min;
    data_t   cur_max;
    logic    is_empty;
    logic    is_full;
    status_t status;
  } rsp_t;

  // One stack entry: value plus running min/max at that depth
  typedef struct packed {
    data_t value;
    data_t min;
    data_t max;
  } entry_t;

  // Shift command shared by every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ===== design/mms_cell.sv =====
module mms_cell (
  input  logic            clk,
  input  mms_pkg::shift_t shift,
  input  mms_pkg::entry_t above,
  input  mms_pkg::entry_t below,
  output mms_pkg::entry_t held
);

  // push moves entries one place deeper, pop one place towards the top
  always_ff @(posedge clk) begin
    if (shift.push) begin
      held <= above;
    end else if (shift.pop) begin
      held <= below;
    end
  end

endmodule

// ===== design/min_max_stack_top.sv =====
// Channel  | Valid      | Stall      | Word
// input    | req_valid  | req_stall  | req (mms_pkg::req_t)
// result   | rsp_valid  | rsp_stall  | rsp (mms_pkg::rsp_t)
//
// One word is taken per cycle while req_stall is low; its result sits in
// the output register in the cycle after acceptance. The output register is
// the only buffer, so req_stall is raised while a result is held and rsp_stall
// is high. Entries live in a row of DEPTH cells that all shift together on
// push/pop. Reset (rst, synchronous) clears the entry count and the output
// valid; cell contents are not reset.
module min_max_stack_top #(
  parameter int DEPTH = mms_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mms_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mms_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            accept;
  mms_pkg::shift_t shift;
  mms_pkg::entry_t new_entry;
  mms_pkg::entry_t held [DEPTH];
  mms_pkg::rsp_t   rsp_next;
  logic            empty;
  logic            full;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));

  // Entry to push: running min/max against the current top
  always_comb begin
    new_entry.value = req.value;
    if (empty) begin
      new_entry.min = req.value;
      new_entry.max = req.value;
    end else begin
      new_entry.min = (req.value < held[0].min) ? req.value : held[0].min;
      new_entry.max = (held[0].max < req.value) ? req.value : held[0].max;
    end
  end

  // Operation decode and result word
  always_comb begin
    shift      = '0;
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = mms_pkg::ST_OK;
    if (req.opcode == mms_pkg::OP_PUSH) begin
      if (full) begin
        rsp_next.status  = mms_pkg::ST_PUSH_FULL;
        rsp_next.cur_min = held[0].min;
        rsp_next.cur_max = held[0].max;
      end else begin
        shift.push       = accept;
        count_next       = count + CW'(1);
        rsp_next.cur_min = new_entry.min;
        rsp_next.cur_max = new_entry.max;
      end
    end else begin
      if (empty) begin
        rsp_next.status = mms_pkg::ST_POP_EMPTY;
      end else begin
        shift.pop       = accept;
        count_next      = count - CW'(1);
        rsp_next.popped = held[0].value;
        if (count != CW'(1)) begin
          rsp_next.cur_min = held[1].min;
          rsp_next.cur_max = held[1].max;
        end
      end
    end
    rsp_next.is_empty = (count_next == '0);
    rsp_next.is_full  = (count_next == CW'(DEPTH));
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mms_pkg::entry_t above;
    mms_pkg::entry_t below;
    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_inner_above
      assign above = held[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner_below
      assign below = held[i+1];
    end
    mms_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .above (above),
      .below (below),
      .held  (held[i])
    );
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== design/mms_check.sv =====
module mms_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input mms_pkg::rsp_t rsp
);

  // nothing pending straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // every accepted word gives a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted word gave no result");

  // empty stack reports zero min/max and cannot be full
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.cur_min == '0 && rsp.cur_max == '0 && !rsp.is_full)
    else $error("empty stack with non-zero min/max");

  // a refused push only happens with the stack full
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == mms_pkg::ST_PUSH_FULL |->
      rsp.is_full && rsp.popped == '0)
    else $error("push-full status on a stack that is not full");

endmodule

bind min_max_stack_top mms_check u_mms_check (.*);
